>>> rtl/core/aihb_pkg.sv
package aihb_pkg;

  // sizes
  localparam int SITES      = 16384;
  localparam int SITE_W     = 14;
  localparam int SITE_AW    = $clog2(SITES);
  localparam int PROB_DEPTH = 1024;
  localparam int TAB_AW     = $clog2(PROB_DEPTH);
  localparam int PROB_W     = 32;
  localparam int RAND_W     = 32;
  localparam int CFG_W      = 16;
  localparam int CFG_DW     = 32;
  localparam int CFG_AW     = 3;
  localparam int MAGSUM_W   = 16;

  // magnetization sum and its magnitude
  localparam int M_W   = SITE_AW + 2;
  localparam int MAG_W = SITE_AW + 1;

  // field, Q7.48, and the sum u = M/SITES + H one bit wider
  localparam int H_W     = 56;
  localparam int H_FRAC  = 48;
  localparam int U_W     = H_W + 1;
  localparam int M_SHIFT = H_FRAC - SITE_AW;
  localparam int AU_LO   = 24;
  localparam int AU_W    = U_W - AU_LO;

  // |u|>>24 times beta; x = 2*prod, saturation at x >= 2^39
  localparam int AX_W    = AU_W + CFG_W;
  localparam int SAT_BIT = 38;
  localparam int IDX_LO  = SAT_BIT - TAB_AW;

  // field step c*|M|*2^32/SITES^2
  localparam int DP_W    = CFG_W + MAG_W;
  localparam int D_SHIFT = 32 - 2 * SITE_AW;
  localparam int D_W     = DP_W + D_SHIFT;

  // clearing pass covers the spin memory and the table load
  localparam int INIT_LEN = (SITES > PROB_DEPTH + 1) ? SITES : PROB_DEPTH + 1;
  localparam int INIT_W   = $clog2(INIT_LEN);

  localparam int DATA_IN_W  = 48;
  localparam int DATA_OUT_W = 80;

  localparam logic [CFG_W-1:0] INV_TEMP_RST = 16'd8192;
  localparam logic [CFG_W-1:0] GAIN_RST     = 16'd655;
  localparam logic signed [M_W-1:0] M_RST   = M_W'(-(SITES % 2));

  // table argument step 8/PROB_DEPTH in Q.60
  localparam logic [63:0] TAB_STEP = (64'd1 << 63) / PROB_DEPTH;

  typedef enum logic [0:0] {
    REG_INV_TEMP      = 1'b0,
    REG_FEEDBACK_GAIN = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SUM,
    ST_MUL,
    ST_DEC,
    ST_FLD
  } seq_state_t;

  typedef struct packed {
    logic              init;
    logic [INIT_W-1:0] init_cnt;
    logic              take;
    logic              sum;
    logic              mul;
    logic              dec;
    logic              commit;
  } seq_ctrl_t;

  // lowest bit first: spin_up, flipped, magnet_sum, field_value
  typedef struct packed {
    logic [H_W-1:0]      field_value;
    logic [MAGSUM_W-1:0] magnet_sum;
    logic                flipped;
    logic                spin_up;
  } result_t;

  typedef logic [PROB_DEPTH-1:0][PROB_W-1:0] prob_tab_t;

  // shift-and-subtract quotient, only used while the table is built
  function automatic logic [63:0] quot64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] q;
    rem = '0;
    q   = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // sigmoid(i*8/PROB_DEPTH) in Q0.32, series for exp(-step) then powers of it
  function automatic prob_tab_t build_prob_tab();
    prob_tab_t    tab;
    logic [63:0]  one;
    logic [63:0]  half;
    logic [63:0]  step;
    logic [63:0]  term;
    logic [63:0]  r;
    logic [63:0]  e;
    logic [63:0]  den;
    logic [127:0] prod;
    one  = 64'd1 << 60;
    half = 64'd1 << 63;
    step = TAB_STEP;
    term = one;
    r    = one;
    e    = one;
    tab  = '0;
    for (int k = 1; k <= 24; k++) begin
      prod = {64'd0, term} * {64'd0, step};
      term = quot64(prod[123:60], 64'(k));
      if ((k & 1) != 0) r = r - term;
      else r = r + term;
    end
    for (int i = 0; i < PROB_DEPTH; i++) begin
      den    = (one + e) >> 29;
      tab[i] = PROB_W'(quot64(half, den));
      prod   = {64'd0, e} * {64'd0, r};
      e      = prod[123:60];
    end
    return tab;
  endfunction

  localparam prob_tab_t PROB_TAB = build_prob_tab();

endpackage

>>> rtl/core/aihb_ram.sv
module aihb_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rd_data_r <= mem_r[raddr];
  end

  assign rdata = rd_data_r;

endmodule

>>> rtl/core/aihb_regs.sv
module aihb_regs
  import aihb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output logic [CFG_W-1:0]  inv_temp,
  output logic [CFG_W-1:0]  feedback_gain
);

  logic [CFG_W-1:0] inv_temp_r;
  logic [CFG_W-1:0] gain_r;
  reg_idx_t         idx;
  logic             wr_en;

  assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_temp_r <= INV_TEMP_RST;
      gain_r     <= GAIN_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_INV_TEMP:      inv_temp_r <= pwdata[CFG_W-1:0];
        REG_FEEDBACK_GAIN: gain_r     <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_INV_TEMP:      prdata = CFG_DW'(inv_temp_r);
      REG_FEEDBACK_GAIN: prdata = CFG_DW'(gain_r);
      default:           prdata = '0;
    endcase
  end

  assign inv_temp      = inv_temp_r;
  assign feedback_gain = gain_r;

endmodule

>>> rtl/core/aihb_seq.sv
module aihb_seq
  import aihb_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      buf_valid,
  input  logic      out_free,
  output seq_ctrl_t ctrl
);

  seq_state_t        state_r;
  seq_state_t        state_nxt;
  logic [INIT_W-1:0] init_cnt_r;
  logic [INIT_W-1:0] init_cnt_nxt;
  logic              init_last;

  assign init_last = (init_cnt_r == INIT_W'(INIT_LEN - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_INIT;
      init_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      init_cnt_r <= init_cnt_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    init_cnt_nxt = init_cnt_r;
    unique case (state_r)
      ST_INIT: begin
        init_cnt_nxt = init_cnt_r + 1'b1;
        if (init_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: if (buf_valid) state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_DEC;
      ST_DEC:  state_nxt = ST_FLD;
      ST_FLD: begin
        if (out_free) state_nxt = buf_valid ? ST_SUM : ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl          = '0;
    ctrl.init_cnt = init_cnt_r;
    unique case (state_r)
      ST_INIT: ctrl.init = 1'b1;
      ST_IDLE: ctrl.take = buf_valid;
      ST_SUM:  ctrl.sum  = 1'b1;
      ST_MUL:  ctrl.mul  = 1'b1;
      ST_DEC:  ctrl.dec  = 1'b1;
      ST_FLD: begin
        ctrl.commit = out_free;
        ctrl.take   = out_free && buf_valid;
      end
      default: ;
    endcase
  end

  // a new word only enters once the previous field update is committed
  a_take_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.take |-> (state_r == ST_IDLE) || ctrl.commit)
    else $error("word taken while an update is in flight");

  a_commit_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.commit && buf_valid) |=> (state_r == ST_SUM))
    else $error("pending word not started after commit");

endmodule

>>> rtl/core/aihb_datapath.sv
module aihb_datapath
  import aihb_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  seq_ctrl_t         ctrl,
  input  logic [SITE_W-1:0] buf_site,
  input  logic [RAND_W-1:0] buf_rand,
  input  logic [CFG_W-1:0]  inv_temp,
  input  logic [CFG_W-1:0]  feedback_gain,
  output result_t           res
);

  localparam logic signed [M_W-1:0] M_STEP = M_W'(2);
  localparam logic signed [M_W-1:0] M_LIM  = M_W'(SITES);
  localparam logic [PROB_W:0]       P_ONE  = {1'b1, {PROB_W{1'b0}}};

  function automatic logic [MAG_W-1:0] mag_of(input logic signed [M_W-1:0] v);
    logic [M_W-1:0] a;
    a = v[M_W-1] ? -v : v;
    return a[MAG_W-1:0];
  endfunction

  // accumulators
  logic signed [M_W-1:0] m_r;
  logic [H_W-1:0]        h_r;

  // word under work
  logic [SITE_W-1:0] site_r;
  logic [RAND_W-1:0] rand_r;
  logic              range_r;

  // sum stage
  logic [AU_W-1:0]  au_r;
  logic             neg_r;
  logic [MAG_W-1:0] magz_r;
  logic [MAG_W-1:0] magp_r;
  logic [MAG_W-1:0] magn_r;

  // multiply stage
  logic            sat_r;
  logic            old_up_r;
  logic [DP_W-1:0] dz_r;
  logic [DP_W-1:0] dp_r;
  logic [DP_W-1:0] dn_r;

  // decide stage
  logic           up_r;
  logic           flip_r;
  logic [D_W-1:0] d_r;

  // table load during the clearing pass
  logic              fill_we_r;
  logic [TAB_AW-1:0] fill_addr_r;
  logic [PROB_W-1:0] fill_data_r;

  logic              site_ok;
  logic [U_W-1:0]    h_ext;
  logic [U_W-1:0]    m_ext;
  logic [U_W-1:0]    u_sum;
  logic [U_W-1:0]    u_abs;
  logic [AX_W-1:0]   ax_prod;
  logic [TAB_AW-1:0] tab_raddr;
  logic [PROB_W-1:0] tab_rd;
  logic              spin_rd;
  logic [PROB_W:0]   p_raw;
  logic [PROB_W:0]   p_sel;
  logic              up;
  logic              flip;
  logic [DP_W-1:0]   d_sel;
  logic [U_W-1:0]    d_ext;
  logic [U_W-1:0]    h_new;
  logic [H_W-1:0]    h_sat;
  logic              spin_we;
  logic [SITE_AW-1:0] spin_waddr;
  logic              spin_wdata;

  assign site_ok = {{(32 - SITE_W){1'b0}}, buf_site} < 32'(SITES);

  // u = H + M/SITES in Q.48, and its magnitude
  assign h_ext = {h_r[H_W-1], h_r};
  assign m_ext = {{(U_W - M_W){m_r[M_W-1]}}, m_r} << M_SHIFT;
  assign u_sum = h_ext + m_ext;
  assign u_abs = u_sum[U_W-1] ? (~u_sum + 1'b1) : u_sum;

  assign ax_prod   = AX_W'(au_r) * AX_W'(inv_temp);
  assign tab_raddr = ax_prod[SAT_BIT-1:IDX_LO];

  assign p_raw = sat_r ? P_ONE : {1'b0, tab_rd};
  assign p_sel = neg_r ? (P_ONE - p_raw) : p_raw;
  assign up    = range_r && ({1'b0, rand_r} < p_sel);
  assign flip  = range_r && (up != old_up_r);
  assign d_sel = flip ? (up ? dp_r : dn_r) : dz_r;

  // field moves against the sign of the new magnetization
  assign d_ext = U_W'(d_r);
  assign h_new = m_r[M_W-1] ? (h_ext + d_ext) : (h_ext - d_ext);

  always_comb begin
    priority if (!h_new[U_W-1] && h_new[U_W-2]) begin
      h_sat = {1'b0, {(H_W - 1){1'b1}}};
    end else if (h_new[U_W-1] && !h_new[U_W-2]) begin
      h_sat = {1'b1, {(H_W - 1){1'b0}}};
    end else begin
      h_sat = h_new[H_W-1:0];
    end
  end

  // spin memory holds the deviation from the alternating reset pattern
  assign spin_we    = ctrl.init || (ctrl.dec && flip);
  assign spin_waddr = ctrl.init ? ctrl.init_cnt[SITE_AW-1:0] : site_r[SITE_AW-1:0];
  assign spin_wdata = ctrl.init ? 1'b0 : (up ^ site_r[0]);

  aihb_ram #(
    .WIDTH (1),
    .DEPTH (SITES)
  ) u_spin_ram (
    .clk   (clk),
    .we    (spin_we),
    .waddr (spin_waddr),
    .wdata (spin_wdata),
    .raddr (site_r[SITE_AW-1:0]),
    .rdata (spin_rd)
  );

  aihb_ram #(
    .WIDTH (PROB_W),
    .DEPTH (PROB_DEPTH)
  ) u_prob_ram (
    .clk   (clk),
    .we    (fill_we_r),
    .waddr (fill_addr_r),
    .wdata (fill_data_r),
    .raddr (tab_raddr),
    .rdata (tab_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_r       <= M_RST;
      h_r       <= '0;
      fill_we_r <= 1'b0;
    end else begin
      fill_we_r <= ctrl.init && (ctrl.init_cnt < INIT_W'(PROB_DEPTH));
      if (ctrl.dec && flip) begin
        m_r <= up ? (m_r + M_STEP) : (m_r - M_STEP);
      end
      if (ctrl.commit) begin
        h_r <= h_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    fill_addr_r <= ctrl.init_cnt[TAB_AW-1:0];
    fill_data_r <= PROB_TAB[ctrl.init_cnt[TAB_AW-1:0]];
    if (ctrl.take) begin
      site_r  <= buf_site;
      rand_r  <= buf_rand;
      range_r <= site_ok;
    end
    if (ctrl.sum) begin
      au_r   <= u_abs[U_W-1:AU_LO];
      neg_r  <= u_sum[U_W-1];
      magz_r <= mag_of(m_r);
      magp_r <= mag_of(m_r + M_STEP);
      magn_r <= mag_of(m_r - M_STEP);
    end
    if (ctrl.mul) begin
      sat_r    <= |ax_prod[AX_W-1:SAT_BIT];
      old_up_r <= spin_rd ^ site_r[0];
      dz_r     <= DP_W'(feedback_gain) * DP_W'(magz_r);
      dp_r     <= DP_W'(feedback_gain) * DP_W'(magp_r);
      dn_r     <= DP_W'(feedback_gain) * DP_W'(magn_r);
    end
    if (ctrl.dec) begin
      up_r   <= up;
      flip_r <= flip;
      d_r    <= range_r ? (D_W'(d_sel) << D_SHIFT) : '0;
    end
  end

  assign res.spin_up     = up_r;
  assign res.flipped     = flip_r;
  assign res.magnet_sum  = MAGSUM_W'(m_r);
  assign res.field_value = h_sat;

  a_m_parity: assert property (@(posedge clk) disable iff (!rst_n)
    m_r[0] == M_RST[0])
    else $error("magnetization parity broken");

  a_m_range: assert property (@(posedge clk) disable iff (!rst_n)
    (m_r <= M_LIM) && (m_r >= -M_LIM))
    else $error("magnetization beyond site count");

  a_h_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !ctrl.commit |=> $stable(h_r))
    else $error("field changed without commit");

endmodule

>>> rtl/core/adaptive_ising_heat_bath_step.sv
// An accepted word goes through the input buffer and the sum, multiply, decide and
// field states to out_tvalid. A new word starts only after the previous field update
// commits, in the loop through the field register (sum, multiply with table read,
// decide with spin write-back, field update). A one-word input buffer and the output
// register let words queue on either side. After rst_n the spin memory is cleared and
// the probability table loaded with in_tready low; the config port works throughout.
module adaptive_ising_heat_bath_step
  import aihb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [DATA_IN_W-1:0]  in_tdata,    // site[13:0], rand_u[45:14]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [DATA_OUT_W-1:0] out_tdata,   // spin_up[0], flipped[1],
                                             // magnet_sum[17:2], field_value[73:18]
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_AW-1:0]     cfg_paddr,
  input  logic [CFG_DW-1:0]     cfg_pwdata,
  output logic [CFG_DW-1:0]     cfg_prdata,
  output logic                  cfg_pready
);

  logic [CFG_W-1:0]  inv_temp;
  logic [CFG_W-1:0]  feedback_gain;
  seq_ctrl_t         ctrl;
  result_t           res;

  logic              buf_valid_r;
  logic              buf_valid_nxt;
  logic [SITE_W-1:0] buf_site_r;
  logic [RAND_W-1:0] buf_rand_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  result_t           out_res_r;
  logic              out_free;
  logic              in_acc;

  aihb_regs u_regs (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (cfg_psel),
    .penable       (cfg_penable),
    .pwrite        (cfg_pwrite),
    .paddr         (cfg_paddr),
    .pwdata        (cfg_pwdata),
    .prdata        (cfg_prdata),
    .pready        (cfg_pready),
    .inv_temp      (inv_temp),
    .feedback_gain (feedback_gain)
  );

  aihb_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .buf_valid (buf_valid_r),
    .out_free  (out_free),
    .ctrl      (ctrl)
  );

  aihb_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (ctrl),
    .buf_site      (buf_site_r),
    .buf_rand      (buf_rand_r),
    .inv_temp      (inv_temp),
    .feedback_gain (feedback_gain),
    .res           (res)
  );

  assign in_tready = !buf_valid_r && !ctrl.init;
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign buf_valid_nxt = in_acc || (buf_valid_r && !ctrl.take);
  assign out_valid_nxt = ctrl.commit || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      buf_valid_r <= buf_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      buf_site_r <= in_tdata[SITE_W-1:0];
      buf_rand_r <= in_tdata[SITE_W +: RAND_W];
    end
    if (ctrl.commit) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = DATA_OUT_W'(out_res_r);

endmodule

>>> sim/tb_top.sv
module tb_top;
  import aihb_pkg::*;

  typedef enum int {BIAS_NONE, BIAS_UP, BIAS_DOWN} rand_bias_t;

  // directed word: site, random fraction, and a hand-typed result where pinned
  typedef struct packed {
    logic [SITE_W-1:0]   site;
    logic [RAND_W-1:0]   rnd;
    bit                  pinned;
    logic                spin;
    logic                flip;
    logic [MAGSUM_W-1:0] mag;
    logic [H_W-1:0]      fld;
  } probe_row_t;

  typedef struct packed {
    logic [CFG_W-1:0] beta;
    logic [CFG_W-1:0] gain;
    bit               rnd_cfg;
    int               idle_pct;
    int               stall_pct;
    int               count;
    rand_bias_t       bias;
  } phase_t;

  typedef struct packed {
    bit      pinned;
    result_t res;
  } pin_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [DATA_IN_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [DATA_OUT_W-1:0] out_tdata;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]     cfg_paddr = '0;
  logic [CFG_DW-1:0]     cfg_pwdata = '0;
  logic [CFG_DW-1:0]     cfg_prdata;
  logic                  cfg_pready;

  adaptive_ising_heat_bath_step u_dut (.*);

  always #10 clk = ~clk;

  // predictor state
  longint unsigned sigmoid_tab [PROB_DEPTH];
  bit              spin_mem [SITES];
  int              magnet;
  longint          field;
  logic [CFG_W-1:0] beta_q;
  logic [CFG_W-1:0] gain_q;
  int              peak_abs_m = 0;
  int              n_flips = 0;

  result_t spin_result_q [$];
  pin_t    pinned_q [$];
  result_t got;
  result_t want;
  pin_t    pin;
  int      n_sent = 0;
  int      n_checked = 0;
  int      n_errors = 0;
  int      idle_pct = 0;
  int      stall_pct = 0;

  localparam probe_row_t PROBES [16] = '{
    '{14'd0,     32'h00000000, 1'b1, 1'b1, 1'b1, 16'd2,      -56'sd20960},
    '{14'd0,     32'hFFFFFFFF, 1'b1, 1'b0, 1'b1, 16'd0,      -56'sd20960},
    '{14'd1,     32'hFFFFFFFF, 1'b1, 1'b0, 1'b1, 16'hFFFE,   56'd0},
    '{14'd1,     32'h00000000, 1'b1, 1'b1, 1'b1, 16'd0,      56'd0},
    '{14'd2,     32'h80000000, 1'b1, 1'b0, 1'b0, 16'd0,      56'd0},
    '{14'd3,     32'h7FFFFFFF, 1'b1, 1'b1, 1'b0, 16'd0,      56'd0},
    '{14'd16383, 32'hFFFFFFFF, 1'b1, 1'b0, 1'b1, 16'hFFFE,   56'd20960},
    '{14'd16382, 32'h00000000, 1'b1, 1'b1, 1'b1, 16'd0,      56'd20960},
    '{14'd16383, 32'h00000000, 1'b0, 1'b0, 1'b0, 16'd0,      56'd0},
    '{14'h2AAA,  32'h55555555, 1'b0, 1'b0, 1'b0, 16'd0,      56'd0},
    '{14'h1555,  32'hAAAAAAAA, 1'b0, 1'b0, 1'b0, 16'd0,      56'd0},
    '{14'd4,     32'h7FFFFFFF, 1'b0, 1'b0, 1'b0, 16'd0,      56'd0},
    '{14'd4,     32'h80000000, 1'b0, 1'b0, 1'b0, 16'd0,      56'd0},
    '{14'd4,     32'h00000001, 1'b0, 1'b0, 1'b0, 16'd0,      56'd0},
    '{14'd100,   32'hFFFFFFFE, 1'b0, 1'b0, 1'b0, 16'd0,      56'd0},
    '{14'd16381, 32'h00000000, 1'b0, 1'b0, 1'b0, 16'd0,      56'd0}
  };

  localparam phase_t PHASES [6] = '{
    '{16'd0,     16'd0,     1'b0, 0,  0,  200, BIAS_NONE},
    '{16'hFFFF,  16'hFFFF,  1'b0, 60, 0,  350, BIAS_UP},
    '{16'hFFFF,  16'd655,   1'b0, 0,  60, 250, BIAS_NONE},
    '{16'd4096,  16'd30000, 1'b0, 37, 37, 350, BIAS_DOWN},
    '{16'd0,     16'd0,     1'b1, 0,  0,  250, BIAS_NONE},
    '{16'd8192,  16'd655,   1'b0, 37, 37, 200, BIAS_NONE}
  };

  function automatic longint unsigned q60_mul(longint unsigned a, longint unsigned b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return 64'(p >> 60);
  endfunction

  // one heat-bath step on the predictor's copy of spins, M and H
  function automatic result_t heat_bath_update(logic [SITE_W-1:0] site,
                                               logic [RAND_W-1:0] rnd);
    result_t         r;
    longint unsigned abs_m;
    longint unsigned m_frac;
    longint unsigned abs_u;
    longint unsigned ax;
    longint unsigned prob;
    longint unsigned dstep;
    longint          u;
    longint          h;
    logic            spin_new;
    r = '0;
    if (site < SITES) begin
      abs_m = 64'((magnet < 0) ? -magnet : magnet);
      if (abs_m >= 64'(SITES)) m_frac = 64'd1 << 48;
      else m_frac = (abs_m << 48) / 64'(SITES);
      u = field + ((magnet < 0) ? -$signed(m_frac) : $signed(m_frac));
      abs_u = (u < 0) ? -u : u;
      ax = (abs_u >> 24) * beta_q * 64'd2;
      if (ax >= (64'd1 << 39)) prob = 64'd1 << 32;
      else prob = sigmoid_tab[(ax * 64'(PROB_DEPTH)) >> 39];
      if (u < 0) prob = (64'd1 << 32) - prob;
      spin_new = ({32'd0, rnd} < prob);
      r.spin_up = spin_new;
      if (spin_new != spin_mem[site]) begin
        r.flipped = 1'b1;
        spin_mem[site] = spin_new;
        magnet += spin_new ? 2 : -2;
        n_flips++;
      end
      abs_m = 64'((magnet < 0) ? -magnet : magnet);
      if (int'(abs_m) > peak_abs_m) peak_abs_m = int'(abs_m);
      dstep = ((gain_q * abs_m) << 32) / (64'(SITES) * 64'(SITES));
      h = field;
      if (magnet > 0) h -= $signed(dstep);
      else if (magnet < 0) h += $signed(dstep);
      if (h > (64'sd1 <<< 55) - 1) h = (64'sd1 <<< 55) - 1;
      if (h < -(64'sd1 <<< 55)) h = -(64'sd1 <<< 55);
      field = h;
    end
    r.magnet_sum  = magnet[MAGSUM_W-1:0];
    r.field_value = field[H_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[$bits(result_t)-1:0];
        n_checked++;
        if (spin_result_q.size() == 0) begin
          $error("result word with nothing outstanding: %h", got);
          n_errors++;
        end else begin
          want = spin_result_q.pop_front();
          if (got.spin_up !== want.spin_up) begin
            $error("spin_up: expected %0d, got %0d", want.spin_up, got.spin_up);
            n_errors++;
          end
          if (got.flipped !== want.flipped) begin
            $error("flipped: expected %0d, got %0d", want.flipped, got.flipped);
            n_errors++;
          end
          if (got.magnet_sum !== want.magnet_sum) begin
            $error("magnet_sum: expected %0d, got %0d",
                   $signed(want.magnet_sum), $signed(got.magnet_sum));
            n_errors++;
          end
          if (got.field_value !== want.field_value) begin
            $error("field_value: expected %0d, got %0d",
                   $signed(want.field_value), $signed(got.field_value));
            n_errors++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        want = heat_bath_update(in_tdata[SITE_W-1:0], in_tdata[SITE_W+RAND_W-1:SITE_W]);
        pin = pinned_q.pop_front();
        spin_result_q.push_back(pin.pinned ? pin.res : want);
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (reg_idx_t'(cfg_paddr[CFG_AW-1:2]))
          REG_INV_TEMP:      beta_q = cfg_pwdata[CFG_W-1:0];
          REG_FEEDBACK_GAIN: gain_q = cfg_pwdata[CFG_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // called at a rising edge, returns at the edge the word is taken
  task automatic send_word(logic [SITE_W-1:0] site, logic [RAND_W-1:0] rnd,
                           bit pinned, result_t res);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    pinned_q.push_back('{pinned, res});
    in_tvalid <= 1'b1;
    in_tdata  <= DATA_IN_W'({rnd, site});
    do @(posedge clk); while (!in_tready);
    n_sent++;
  endtask

  task automatic apb_write(reg_idx_t idx, logic [CFG_W-1:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_AW'({idx, 2'b00});
    cfg_pwdata  <= {16'($urandom), val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (n_checked < n_sent) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    longint unsigned step;
    longint unsigned term;
    longint unsigned ratio;
    longint unsigned e;
    logic [CFG_W-1:0] beta;
    logic [CFG_W-1:0] gain;
    logic [SITE_W-1:0] site;
    logic [RAND_W-1:0] rnd;
    result_t res;

    // sigmoid table: exp(-8/depth) by series, then its powers
    step  = (64'd1 << 63) / 64'(PROB_DEPTH);
    term  = 64'd1 << 60;
    ratio = 64'd1 << 60;
    e     = 64'd1 << 60;
    for (int k = 1; k <= 24; k++) begin
      term = q60_mul(term, step) / 64'(k);
      if (k % 2 == 1) ratio -= term;
      else ratio += term;
    end
    for (int i = 0; i < PROB_DEPTH; i++) begin
      sigmoid_tab[i] = (64'd1 << 63) / (((64'd1 << 60) + e) >> 29);
      e = q60_mul(e, ratio);
    end
    for (int i = 0; i < SITES; i++) spin_mem[i] = i[0];
    magnet = 0;
    field  = 0;
    beta_q = INV_TEMP_RST;
    gain_q = GAIN_RST;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (PROBES[i]) begin
      res = '0;
      res.spin_up     = PROBES[i].spin;
      res.flipped     = PROBES[i].flip;
      res.magnet_sum  = PROBES[i].mag;
      res.field_value = PROBES[i].fld;
      send_word(PROBES[i].site, PROBES[i].rnd, PROBES[i].pinned, res);
    end
    drain();

    foreach (PHASES[p]) begin
      beta = PHASES[p].rnd_cfg ? CFG_W'($urandom) : PHASES[p].beta;
      gain = PHASES[p].rnd_cfg ? CFG_W'($urandom) : PHASES[p].gain;
      apb_write(REG_INV_TEMP, beta);
      apb_write(REG_FEEDBACK_GAIN, gain);
      idle_pct  = PHASES[p].idle_pct;
      stall_pct = PHASES[p].stall_pct;
      for (int n = 0; n < PHASES[p].count; n++) begin
        // a quarter of updates revisit a small window so sites flip back
        site = ($urandom_range(3) == 0) ? SITE_W'($urandom_range(31)) : SITE_W'($urandom);
        rnd  = $urandom;
        if ($urandom_range(3) != 0) begin
          if (PHASES[p].bias == BIAS_UP) rnd = $urandom_range(32'h00FFFFFF);
          else if (PHASES[p].bias == BIAS_DOWN) rnd = 32'hFFFFFFFF - $urandom_range(32'h00FFFFFF);
        end
        send_word(site, rnd, 1'b0, '0);
      end
      drain();
    end

    if (spin_result_q.size() != 0) begin
      $error("%0d expected results never arrived", spin_result_q.size());
      n_errors++;
    end
    $display("%0d spin updates checked across %0d beta/gain settings, %0d flips",
             n_checked, $size(PHASES) + 1, n_flips);
    $display("largest |M| reached %0d; sender and receiver idled up to 60%% of cycles",
             peak_abs_m);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #(20 * 400000);
    $display("FAIL");
    $finish;
  end

endmodule

>>> adaptive_ising_heat_bath_step.f
rtl/core/aihb_pkg.sv
rtl/core/aihb_ram.sv
rtl/core/aihb_regs.sv
rtl/core/aihb_seq.sv
rtl/core/aihb_datapath.sv
rtl/core/adaptive_ising_heat_bath_step.sv
sim/tb_top.sv
